/* rtl/lbs_pkg.sv */
// ============================================================================
// lbs_pkg: shared types and helpers for the linear blend skinning engine
// Request format, action codes, sequencer states and fixed-point helpers.
// ============================================================================
package lbs_pkg;

    localparam int BONES_DEF      = 32;
    localparam int VERTICES_DEF   = 4096;
    localparam int WORDS_PER_BONE = 12;
    localparam int SLOT_TRANS     = 9;     // first translation word
    localparam int BONE_IDX_W     = 8;     // holds any wrapped bone index
    localparam int VTX_IDX_W      = 16;    // holds any wrapped vertex index
    localparam int QUEUE_DEPTH    = 2;
    localparam int SUM_W          = 51;    // exact row sum width
    localparam int PROD_W         = 65;    // 32 x 33 signed product
    localparam int RND_W          = PROD_W - 16;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_POS   = 2'd2,
        ACT_NORM  = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCRD,
        ST_ADDR,
        ST_DATA,
        ST_SUM,
        ST_WMUL,
        ST_WACC,
        ST_WRITE
    } back_st_t;

    typedef struct packed {
        act_t                   action;
        logic [BONE_IDX_W-1:0]  bone_idx;
        logic [3:0]             slot;
        logic [31:0]            value;
        logic [VTX_IDX_W-1:0]   vtx_idx;
        logic [16:0]            weight;
        logic [31:0]            data_x;
        logic [31:0]            data_y;
        logic [31:0]            data_z;
        logic [31:0]            offset_x;
        logic [31:0]            offset_y;
        logic [31:0]            offset_z;
    } item_t;

    // sign-extend a 32-bit word to the sum width
    function automatic logic signed [SUM_W-1:0] sx32(input logic [31:0] v);
        return $signed({{(SUM_W-32){v[31]}}, v});
    endfunction

    // saturate to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1)
            return v[31:0];
        else if (v[SUM_W-1])
            return 32'h8000_0000;
        else
            return 32'h7fff_ffff;
    endfunction

    // add half an LSB, then floor shift by 16: nearest, ties upward
    function automatic logic signed [RND_W-1:0] round16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] y;
        y = p + PROD_W'(32768);
        return y[PROD_W-1:16];
    endfunction

endpackage

/* rtl/lbs_ram.sv */
// ============================================================================
// lbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lbs_front.sv */
// ============================================================================
// lbs_front: request intake
// Registers each request, wraps bone and vertex indexes, feeds the queue.
// ============================================================================
module lbs_front #(
    parameter int BONES    = lbs_pkg::BONES_DEF,
    parameter int VERTICES = lbs_pkg::VERTICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     action,
    input  logic [4:0]     bone,
    input  logic [3:0]     matrix_slot,
    input  logic [31:0]    matrix_value,
    input  logic [11:0]    vertex,
    input  logic [16:0]    weight,
    input  logic [31:0]    data_x,
    input  logic [31:0]    data_y,
    input  logic [31:0]    data_z,
    input  logic [31:0]    offset_x,
    input  logic [31:0]    offset_y,
    input  logic [31:0]    offset_z,
    output logic           push,
    output lbs_pkg::item_t push_item,
    input  logic           full
);
    import lbs_pkg::*;

    localparam int RECIP_SHIFT = 24;
    localparam int VTX_RECIP   = (1 << RECIP_SHIFT) / VERTICES;

    logic [BONE_IDX_W-1:0] bone_map [32];
    logic                  stg_valid_reg, stg_valid_next;
    item_t                 stg_reg;
    logic [11:0]           quot_reg;
    logic [35:0]           quot_prod;
    logic [28:0]           quot_v;
    logic [16:0]           rem_raw, rem_w;
    logic                  take;

    // bone wrap table, built at elaboration
    for (genvar g = 0; g < 32; g++)
    begin : g_bone
        assign bone_map[g] = BONE_IDX_W'(g % BONES);
    end

    // handshake
    assign in_stall       = stg_valid_reg && full;
    assign take           = in_valid && !in_stall;
    assign push           = stg_valid_reg && !full;
    assign stg_valid_next = take || (stg_valid_reg && !push);

    // vertex wrap: quotient estimate by reciprocal, then one correction
    assign quot_prod = 36'(vertex) * 36'(VTX_RECIP);
    assign quot_v    = 29'(quot_reg) * 29'(VERTICES);
    assign rem_raw   = 17'(29'(stg_reg.vtx_idx) - quot_v);
    assign rem_w     = (rem_raw >= 17'(VERTICES)) ? rem_raw - 17'(VERTICES) : rem_raw;

    always_comb
    begin
        push_item         = stg_reg;
        push_item.vtx_idx = VTX_IDX_W'(rem_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_reg.action   <= act_t'(action);
            stg_reg.bone_idx <= bone_map[bone];
            stg_reg.slot     <= matrix_slot;
            stg_reg.value    <= matrix_value;
            stg_reg.vtx_idx  <= VTX_IDX_W'(vertex);
            stg_reg.weight   <= weight;
            stg_reg.data_x   <= data_x;
            stg_reg.data_y   <= data_y;
            stg_reg.data_z   <= data_z;
            stg_reg.offset_x <= offset_x;
            stg_reg.offset_y <= offset_y;
            stg_reg.offset_z <= offset_z;
            quot_reg         <= quot_prod[35:24];
        end
    end

endmodule

/* rtl/lbs_fifo.sv */
// ============================================================================
// lbs_fifo: request queue
// Small register queue between intake and the skinning sequencer.
// ============================================================================
module lbs_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lbs_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output lbs_pkg::item_t head,
    output logic           empty
);
    import lbs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/lbs_back.sv */
// ============================================================================
// lbs_back: skinning sequencer
// Executes queued requests: matrix loads, clears and skin updates through
// one shared multiplier, the bone word RAM and the two accumulator RAMs.
// ============================================================================
module lbs_back #(
    parameter int BONES    = lbs_pkg::BONES_DEF,
    parameter int VERTICES = lbs_pkg::VERTICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lbs_pkg::item_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [11:0]    result_vertex,
    output logic           is_normal,
    output logic [31:0]    sum_x,
    output logic [31:0]    sum_y,
    output logic [31:0]    sum_z
);
    import lbs_pkg::*;

    localparam int BDEPTH = BONES * WORDS_PER_BONE;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int VAW    = $clog2(VERTICES);

    back_st_t                 st_reg, st_next;
    logic                     norm_reg, norm_next;
    logic [VAW-1:0]           vtx_reg, vtx_next;
    logic [16:0]              w_reg, w_next;
    logic [BAW-1:0]           base_reg, base_next;
    logic [31:0]              q_reg [3];
    logic [31:0]              q_next [3];
    logic [31:0]              acc_reg [3];
    logic [31:0]              acc_next [3];
    logic signed [SUM_W-1:0]  s_reg, s_next;
    logic [31:0]              word_reg, word_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [1:0]               r_reg, r_next, j_reg, j_next;
    logic                     out_valid_reg, out_valid_next;
    logic [11:0]              out_vtx_reg, out_vtx_next;
    logic                     out_norm_reg, out_norm_next;
    logic [31:0]              out_sum_reg [3];
    logic [31:0]              out_sum_next [3];

    // memory ports
    logic                     b_wr_en, b_rd_en;
    logic [BAW-1:0]           b_wr_addr, b_rd_addr;
    logic [31:0]              b_rd_data;
    logic                     p_wr_en, n_wr_en, acc_rd_en;
    logic [VAW-1:0]           acc_wr_addr, acc_rd_addr;
    logic [95:0]              acc_wr_data, p_rd_data, n_rd_data;

    // shared multiplier
    logic signed [31:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [PROD_W-1:0] mul_out;
    logic [31:0]              q_sel, acc_sel;

    assign mul_out = mul_a * mul_b;

    assign out_valid     = out_valid_reg;
    assign result_vertex = out_vtx_reg;
    assign is_normal     = out_norm_reg;
    assign sum_x         = out_sum_reg[0];
    assign sum_y         = out_sum_reg[1];
    assign sum_z         = out_sum_reg[2];

    lbs_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_bone_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (head.value),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    lbs_ram #(.WIDTH(96), .DEPTH(VERTICES)) u_pos_ram (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (acc_wr_addr),
        .wr_data (acc_wr_data),
        .rd_en   (acc_rd_en),
        .rd_addr (acc_rd_addr),
        .rd_data (p_rd_data)
    );

    lbs_ram #(.WIDTH(96), .DEPTH(VERTICES)) u_nrm_ram (
        .clk     (clk),
        .wr_en   (n_wr_en),
        .wr_addr (acc_wr_addr),
        .wr_data (acc_wr_data),
        .rd_en   (acc_rd_en),
        .rd_addr (acc_rd_addr),
        .rd_data (n_rd_data)
    );

    // operand selects for the current column and row
    always_comb
    begin
        unique case (j_reg)
            2'd0:    q_sel = q_reg[0];
            2'd1:    q_sel = q_reg[1];
            default: q_sel = q_reg[2];
        endcase
        unique case (r_reg)
            2'd0:    acc_sel = acc_reg[0];
            2'd1:    acc_sel = acc_reg[1];
            default: acc_sel = acc_reg[2];
        endcase
    end

    // sequencer: next state, datapath and memory control
    always_comb
    begin
        st_next        = st_reg;
        norm_next      = norm_reg;
        vtx_next       = vtx_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        s_next         = s_reg;
        word_next      = word_reg;
        prod_next      = prod_reg;
        r_next         = r_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_vtx_next   = out_vtx_reg;
        out_norm_next  = out_norm_reg;
        out_sum_next   = out_sum_reg;
        pop            = 1'b0;
        b_wr_en        = 1'b0;
        b_wr_addr      = BAW'(head.bone_idx) * BAW'(WORDS_PER_BONE) + BAW'(head.slot);
        b_rd_en        = 1'b0;
        b_rd_addr      = base_reg + ((j_reg == 2'd3)
                         ? BAW'(SLOT_TRANS) + BAW'(r_reg)
                         : BAW'(r_reg) * BAW'(3) + BAW'(j_reg));
        p_wr_en        = 1'b0;
        n_wr_en        = 1'b0;
        acc_wr_addr    = vtx_reg;
        acc_wr_data    = {acc_reg[2], acc_reg[1], acc_reg[0]};
        acc_rd_en      = 1'b0;
        acc_rd_addr    = VAW'(head.vtx_idx);
        mul_a          = $signed(b_rd_data);
        mul_b          = $signed({q_sel[31], q_sel});

        unique case (st_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.action)
                        ACT_LOAD:
                        begin
                            b_wr_en = (head.slot < 4'(WORDS_PER_BONE));
                        end
                        ACT_CLEAR:
                        begin
                            acc_wr_addr = VAW'(head.vtx_idx);
                            acc_wr_data = '0;
                            p_wr_en     = 1'b1;
                            n_wr_en     = 1'b1;
                        end
                        default:
                        begin
                            acc_rd_en = 1'b1;
                            norm_next = (head.action == ACT_NORM);
                            vtx_next  = VAW'(head.vtx_idx);
                            w_next    = head.weight;
                            base_next = BAW'(head.bone_idx) * BAW'(WORDS_PER_BONE);
                            if (head.action == ACT_NORM)
                            begin
                                q_next[0] = head.data_x;
                                q_next[1] = head.data_y;
                                q_next[2] = head.data_z;
                            end
                            else
                            begin
                                q_next[0] = sat32(sx32(head.data_x) + sx32(head.offset_x));
                                q_next[1] = sat32(sx32(head.data_y) + sx32(head.offset_y));
                                q_next[2] = sat32(sx32(head.data_z) + sx32(head.offset_z));
                            end
                            s_next  = '0;
                            r_next  = '0;
                            j_next  = '0;
                            st_next = ST_ACCRD;
                        end
                    endcase
                end
            end
            ST_ACCRD:
            begin
                acc_next[0] = norm_reg ? n_rd_data[31:0]  : p_rd_data[31:0];
                acc_next[1] = norm_reg ? n_rd_data[63:32] : p_rd_data[63:32];
                acc_next[2] = norm_reg ? n_rd_data[95:64] : p_rd_data[95:64];
                st_next     = ST_ADDR;
            end
            ST_ADDR:
            begin
                b_rd_en = 1'b1;
                st_next = ST_DATA;
            end
            ST_DATA:
            begin
                word_next = b_rd_data;
                prod_next = mul_out;
                st_next   = ST_SUM;
            end
            ST_SUM:
            begin
                if (j_reg == 2'd3)
                begin
                    s_next  = s_reg + sx32(word_reg);
                    st_next = ST_WMUL;
                end
                else
                begin
                    s_next = s_reg + SUM_W'(round16(prod_reg));
                    j_next = j_reg + 2'd1;
                    // normals skip the translation word
                    st_next = (j_reg == 2'd2 && norm_reg) ? ST_WMUL : ST_ADDR;
                end
            end
            ST_WMUL:
            begin
                mul_a     = $signed(sat32(s_reg));
                mul_b     = $signed({16'd0, w_reg});
                prod_next = mul_out;
                st_next   = ST_WACC;
            end
            ST_WACC:
            begin
                acc_next[r_reg] = sat32(sx32(acc_sel) + SUM_W'(round16(prod_reg)));
                s_next          = '0;
                j_next          = '0;
                r_next          = r_reg + 2'd1;
                st_next         = (r_reg == 2'd2) ? ST_WRITE : ST_ADDR;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg)
                begin
                    p_wr_en         = !norm_reg;
                    n_wr_en         = norm_reg;
                    out_valid_next  = 1'b1;
                    out_vtx_next    = 12'(vtx_reg);
                    out_norm_next   = norm_reg;
                    out_sum_next[0] = acc_reg[0];
                    out_sum_next[1] = acc_reg[1];
                    out_sum_next[2] = acc_reg[2];
                    st_next         = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        norm_reg     <= norm_next;
        vtx_reg      <= vtx_next;
        w_reg        <= w_next;
        base_reg     <= base_next;
        q_reg        <= q_next;
        acc_reg      <= acc_next;
        s_reg        <= s_next;
        word_reg     <= word_next;
        prod_reg     <= prod_next;
        r_reg        <= r_next;
        j_reg        <= j_next;
        out_vtx_reg  <= out_vtx_next;
        out_norm_reg <= out_norm_next;
        out_sum_reg  <= out_sum_next;
    end

endmodule

/* rtl/linear_blend_vertex_skinning.sv */
// Each request is registered at intake and queued; the sequencer then writes
// loads and clears, and steps skins one matrix word at a time.
// Throughput: one load or clear per cycle while the sequencer is idle; a skin
// holds the sequencer until its result is registered, as it shares the one
// multiplier and the single read port of the bone word RAM.
// Reset: asynchronous, active low; clears queue and control state only.
// ============================================================================
// linear_blend_vertex_skinning: linear blend skinning engine
// Intake stage, request queue and skinning sequencer with RAM storage.
// ============================================================================
module linear_blend_vertex_skinning #(
    parameter int BONES    = lbs_pkg::BONES_DEF,
    parameter int VERTICES = lbs_pkg::VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [4:0]  bone,
    input  logic [3:0]  matrix_slot,
    input  logic [31:0] matrix_value,
    input  logic [11:0] vertex,
    input  logic [16:0] weight,
    input  logic [31:0] data_x,
    input  logic [31:0] data_y,
    input  logic [31:0] data_z,
    input  logic [31:0] offset_x,
    input  logic [31:0] offset_y,
    input  logic [31:0] offset_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] result_vertex,
    output logic        is_normal,
    output logic [31:0] sum_x,
    output logic [31:0] sum_y,
    output logic [31:0] sum_z
);
    import lbs_pkg::*;

    logic  push, full, pop, empty;
    item_t push_item, head;

    lbs_front #(.BONES(BONES), .VERTICES(VERTICES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .bone         (bone),
        .matrix_slot  (matrix_slot),
        .matrix_value (matrix_value),
        .vertex       (vertex),
        .weight       (weight),
        .data_x       (data_x),
        .data_y       (data_y),
        .data_z       (data_z),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .offset_z     (offset_z),
        .push         (push),
        .push_item    (push_item),
        .full         (full)
    );

    lbs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    lbs_back #(.BONES(BONES), .VERTICES(VERTICES)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_vertex (result_vertex),
        .is_normal     (is_normal),
        .sum_x         (sum_x),
        .sum_y         (sum_y),
        .sum_z         (sum_z)
    );

endmodule

/* rtl/lbs_checker.sv */
// ============================================================================
// lbs_checker: port-level checks for the skinning engine
// Result channel behavior across reset, stalls and delivery.
// ============================================================================
module lbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] result_vertex,
    input logic        is_normal,
    input logic [31:0] sum_x,
    input logic [31:0] sum_y,
    input logic [31:0] sum_z
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sum_x) && $stable(sum_y) && $stable(sum_z)
            && $stable(result_vertex) && $stable(is_normal))
        else $error("result payload changed while stalled");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // a result loads only into an empty output register: never back to back
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("results delivered on consecutive cycles");

endmodule

bind linear_blend_vertex_skinning lbs_checker u_lbs_checker (.*);

/* verif/linear_blend_vertex_skinning_tb.sv */
// ============================================================================
// linear_blend_vertex_skinning_tb: self-checking bench for the skinning engine
// Loads bone matrices, clears vertices and streams skin requests through the
// valid/stall handshake; every result is compared against a local predictor.
// ============================================================================
module linear_blend_vertex_skinning_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbs_pkg::*;

    localparam int NBONE   = 32;
    localparam int NVTX    = 4096;
    localparam int WD_LIM  = 20000;

    typedef struct {
        act_t        act;
        logic [4:0]  bone_i;
        logic [3:0]  slot;
        logic [31:0] value;
        logic [11:0] vtx;
        logic [16:0] wgt;
        logic [31:0] d [3];
        logic [31:0] o [3];
    } req_t;

    typedef struct {
        logic [11:0] vtx;
        logic        nrm;
        logic [31:0] s [3];
    } skin_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [4:0]  bone;
    logic [3:0]  matrix_slot;
    logic [31:0] matrix_value;
    logic [11:0] vertex;
    logic [16:0] weight;
    logic [31:0] data_x, data_y, data_z;
    logic [31:0] offset_x, offset_y, offset_z;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] result_vertex;
    logic        is_normal;
    logic [31:0] sum_x, sum_y, sum_z;

    linear_blend_vertex_skinning u_dut (.*);

    // predictor state
    logic signed [31:0] bone_mat [NBONE*12];
    logic signed [31:0] pos_acc [NVTX][3];
    logic signed [31:0] nrm_acc [NVTX][3];
    bit                 cleared [NVTX];
    bit                 loaded [NBONE];

    req_t      pending_reqs[$];
    skin_res_t expected_sums[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off;
    bit  failed;
    int  quiet_cycles;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // round to nearest, ties toward plus infinity: arithmetic shift is a floor
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + 64'sd32768;
        return y >>> 16;
    endfunction

    // apply one request to the predictor, queue a result for skin requests
    function automatic void predict_skin(input req_t r);
        logic signed [63:0] q [3];
        logic signed [63:0] s;
        logic signed [31:0] t;
        int base;
        skin_res_t e;
        bit nrm;
        case (r.act)
            ACT_LOAD:
                if (r.slot < WORDS_PER_BONE) bone_mat[r.bone_i*12 + r.slot] = r.value;
            ACT_CLEAR:
                for (int k = 0; k < 3; k++)
                begin
                    pos_acc[r.vtx][k] = '0;
                    nrm_acc[r.vtx][k] = '0;
                end
            default:
            begin
                nrm = (r.act == ACT_NORM);
                base = r.bone_i * 12;
                for (int c = 0; c < 3; c++)
                begin
                    q[c] = $signed(r.d[c]);
                    if (!nrm) q[c] = clamp32(q[c] + $signed(r.o[c]));
                end
                for (int k = 0; k < 3; k++)
                begin
                    s = 0;
                    for (int c = 0; c < 3; c++)
                        s += rnd16(64'(bone_mat[base + 3*k + c]) * q[c]);
                    if (!nrm) s += bone_mat[base + SLOT_TRANS + k];
                    t = clamp32(s);
                    if (nrm)
                        nrm_acc[r.vtx][k] = clamp32(64'(nrm_acc[r.vtx][k])
                                                    + rnd16(64'(t) * $signed({1'b0, r.wgt})));
                    else
                        pos_acc[r.vtx][k] = clamp32(64'(pos_acc[r.vtx][k])
                                                    + rnd16(64'(t) * $signed({1'b0, r.wgt})));
                    e.s[k] = nrm ? nrm_acc[r.vtx][k] : pos_acc[r.vtx][k];
                end
                e.vtx = r.vtx;
                e.nrm = nrm;
                expected_sums.push_back(e);
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 131072) - 65536;
            3: return $urandom_range(0, 8388608) - 4194304;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_req(input act_t a, input int b, input int sl,
                                    input logic [31:0] val, input int v, input int w);
        req_t r;
        r.act = a; r.bone_i = 5'(b); r.slot = 4'(sl); r.value = val;
        r.vtx = 12'(v); r.wgt = 17'(w);
        for (int k = 0; k < 3; k++)
        begin
            r.d[k] = rand_word();
            r.o[k] = rand_word();
        end
        if (a == ACT_CLEAR) cleared[v] = 1;
        pending_reqs.push_back(r);
    endfunction

    // a bone counts as loaded only once all twelve words are written
    function automatic void load_bone(input int b);
        for (int k = 0; k < 12; k++) add_req(ACT_LOAD, b, k, rand_word(), 0, 0);
        loaded[b] = 1;
    endfunction

    // well-formed random request: skins only touch loaded bones, cleared vertices
    function automatic void add_random();
        int b, v, sel;
        sel = $urandom_range(0, 99);
        b = $urandom_range(0, NBONE-1);
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NVTX-1) : $urandom_range(0, 31);
        if (sel < 12)
            add_req(ACT_LOAD, b, $urandom_range(0, 15), rand_word(), $urandom, $urandom);
        else if (sel < 25 || !cleared[v])
            add_req(ACT_CLEAR, $urandom, $urandom, $urandom, v, $urandom);
        else
        begin
            if (!loaded[b]) load_bone(b);
            add_req(sel < 62 ? ACT_POS : ACT_NORM, b, $urandom, $urandom, v,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(65536, 131071)
                                                : $urandom_range(0, 65536));
        end
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            {action, bone, matrix_slot, matrix_value, vertex, weight} <= '0;
            {data_x, data_y, data_z, offset_x, offset_y, offset_z} <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid) predict_skin(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid     <= 1;
                action       <= pending_reqs[0].act;
                bone         <= pending_reqs[0].bone_i;
                matrix_slot  <= pending_reqs[0].slot;
                matrix_value <= pending_reqs[0].value;
                vertex       <= pending_reqs[0].vtx;
                weight       <= pending_reqs[0].wgt;
                data_x       <= pending_reqs[0].d[0];
                data_y       <= pending_reqs[0].d[1];
                data_z       <= pending_reqs[0].d[2];
                offset_x     <= pending_reqs[0].o[0];
                offset_y     <= pending_reqs[0].o[1];
                offset_z     <= pending_reqs[0].o[2];
            end
            else
                in_valid <= 0;
        end
    end

    // result stall control, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1;
        else if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_stall <= 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        skin_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("unexpected result for vertex %0d", result_vertex);
                failed = 1;
            end
            else
            begin
                e = expected_sums.pop_front();
                if (result_vertex !== e.vtx)
                begin
                    $error("result_vertex: expected %0d, got %0d", e.vtx, result_vertex);
                    failed = 1;
                end
                if (is_normal !== e.nrm)
                begin
                    $error("is_normal: expected %0d, got %0d", e.nrm, is_normal);
                    failed = 1;
                end
                if (sum_x !== e.s[0])
                begin
                    $error("sum_x: expected %h, got %h", e.s[0], sum_x);
                    failed = 1;
                end
                if (sum_y !== e.s[1])
                begin
                    $error("sum_y: expected %h, got %h", e.s[1], sum_y);
                    failed = 1;
                end
                if (sum_z !== e.s[2])
                begin
                    $error("sum_z: expected %h, got %h", e.s[2], sum_z);
                    failed = 1;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIM)
        begin
            $display("FAIL linear_blend_vertex_skinning");
            $finish;
        end
    end

    task automatic drain_all();
        while (pending_reqs.size() > 0 || in_valid || expected_sums.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        failed = 0;
        quiet_cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // falling edge after time zero so every async reset sees it
        rst_n = 1;
        #1;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: full bone, extremes, bad slots, edge indexes, weights
        load_bone(0);
        load_bone(NBONE-1);
        add_req(ACT_LOAD, 0, 12, 32'h1234_5678, 0, 0);
        add_req(ACT_LOAD, 0, 15, 32'hffff_ffff, 0, 0);
        add_req(ACT_CLEAR, 0, 0, 0, 0, 0);
        add_req(ACT_CLEAR, 0, 0, 0, NVTX-1, 0);
        add_req(ACT_POS, 0, 0, 0, 0, 65536);
        add_req(ACT_NORM, NBONE-1, 0, 0, NVTX-1, 131071);
        add_req(ACT_POS, NBONE-1, 0, 0, NVTX-1, 0);
        add_req(ACT_NORM, 0, 0, 0, 0, 1);
        add_req(ACT_POS, 0, 0, 0, 0, 131071);
        drain_all();

        // random phases: free after a long hold-off, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 73) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 73) : 0;
            for (int n = 0; n < 350; n++) add_random();
            if (ph == 0) hold_off = 400;
            drain_all();
        end

        repeat (60) @(posedge clk);
        if (!failed)
            $display("PASS linear_blend_vertex_skinning");
        else
            $display("FAIL linear_blend_vertex_skinning");
        $finish;
    end
endmodule

/* filelist.f */
rtl/lbs_pkg.sv
rtl/lbs_ram.sv
rtl/lbs_front.sv
rtl/lbs_fifo.sv
rtl/lbs_back.sv
rtl/linear_blend_vertex_skinning.sv
rtl/lbs_checker.sv
verif/linear_blend_vertex_skinning_tb.sv
